FILE: src/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned NUM_CELLS = 8;  // one cell per quotient bit
  localparam int unsigned SAT_NUM_W = 16;
  localparam int unsigned HUE_NUM_W = 14;
  localparam int unsigned DSH_W     = 15;

  localparam logic [5:0]       SIXTH_STEP = 6'd43;
  localparam logic [PIX_W-1:0] BASE_RED   = 8'd0;
  localparam logic [PIX_W-1:0] BASE_GREEN = 8'd85;
  localparam logic [PIX_W-1:0] BASE_BLUE  = 8'd171;

  // Payload carried from cell to cell along the divider chain.
  typedef struct packed {
    logic [SAT_NUM_W-1:0] sat_rem;
    logic [DSH_W-1:0]     sat_dsh;
    logic [PIX_W-1:0]     sat_q;
    logic [HUE_NUM_W-1:0] hue_rem;
    logic [DSH_W-1:0]     hue_dsh;
    logic [PIX_W-1:0]     hue_q;
    logic                 hue_neg;
    logic [PIX_W-1:0]     hue_base;
    logic [PIX_W-1:0]     value;
  } stage_t;

endpackage

FILE: src/rgbhsv_prep.sv
module rgbhsv_prep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [rgbhsv_pkg::PIX_W-1:0] red_level,
  input  logic [rgbhsv_pkg::PIX_W-1:0] green_level,
  input  logic [rgbhsv_pkg::PIX_W-1:0] blue_level,
  output logic                         valid_r,
  output rgbhsv_pkg::stage_t           data_r
);

  logic [rgbhsv_pkg::PIX_W-1:0] hi_rg;
  logic [rgbhsv_pkg::PIX_W-1:0] hi;
  logic [rgbhsv_pkg::PIX_W-1:0] lo_rg;
  logic [rgbhsv_pkg::PIX_W-1:0] lo;
  logic [rgbhsv_pkg::PIX_W-1:0] chroma;
  logic [rgbhsv_pkg::PIX_W-1:0] pos_a;
  logic [rgbhsv_pkg::PIX_W-1:0] neg_a;
  logic [rgbhsv_pkg::PIX_W-1:0] base;
  logic                         diff_neg;
  logic [rgbhsv_pkg::PIX_W-1:0] diff_abs;
  logic                         valid_nxt;
  rgbhsv_pkg::stage_t           data_nxt;

  always_comb begin
    hi_rg  = (red_level > green_level) ? red_level : green_level;
    hi     = (hi_rg > blue_level) ? hi_rg : blue_level;
    lo_rg  = (red_level < green_level) ? red_level : green_level;
    lo     = (lo_rg < blue_level) ? lo_rg : blue_level;
    chroma = hi - lo;

    // Red wins ties over green and blue, green wins over blue.
    priority if (hi == red_level) begin
      base  = rgbhsv_pkg::BASE_RED;
      pos_a = green_level;
      neg_a = blue_level;
    end else if (hi == green_level) begin
      base  = rgbhsv_pkg::BASE_GREEN;
      pos_a = blue_level;
      neg_a = red_level;
    end else begin
      base  = rgbhsv_pkg::BASE_BLUE;
      pos_a = red_level;
      neg_a = green_level;
    end

    diff_neg = pos_a < neg_a;
    diff_abs = diff_neg ? (neg_a - pos_a) : (pos_a - neg_a);

    // Both quotients fit in eight bits, so the divisor starts shifted by seven.
    // Saturation divides by the value, hue by the chroma.
    data_nxt.sat_rem  = {chroma, 8'd0} - {8'd0, chroma};
    data_nxt.sat_dsh  = {hi, 7'd0};
    data_nxt.sat_q    = '0;
    data_nxt.hue_rem  = rgbhsv_pkg::HUE_NUM_W'(diff_abs * rgbhsv_pkg::SIXTH_STEP);
    data_nxt.hue_dsh  = {chroma, 7'd0};
    data_nxt.hue_q    = '0;
    data_nxt.hue_neg  = diff_neg;
    data_nxt.hue_base = base;
    data_nxt.value    = hi;
    valid_nxt         = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: src/rgbhsv_div_cell.sv
module rgbhsv_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  input  rgbhsv_pkg::stage_t data_in,
  output logic               valid_r,
  output rgbhsv_pkg::stage_t data_r
);

  logic               sat_ge;
  logic               hue_ge;
  logic               valid_nxt;
  rgbhsv_pkg::stage_t data_nxt;

  // One restoring step for each of the two divisions.
  always_comb begin
    data_nxt = data_in;
    sat_ge   = data_in.sat_rem >= {1'b0, data_in.sat_dsh};
    hue_ge   = {1'b0, data_in.hue_rem} >= data_in.hue_dsh;
    if (sat_ge) begin
      data_nxt.sat_rem = data_in.sat_rem - {1'b0, data_in.sat_dsh};
    end
    if (hue_ge) begin
      data_nxt.hue_rem = rgbhsv_pkg::HUE_NUM_W'({1'b0, data_in.hue_rem} - data_in.hue_dsh);
    end
    data_nxt.sat_q   = {data_in.sat_q[rgbhsv_pkg::PIX_W-2:0], sat_ge};
    data_nxt.hue_q   = {data_in.hue_q[rgbhsv_pkg::PIX_W-2:0], hue_ge};
    data_nxt.sat_dsh = data_in.sat_dsh >> 1;
    data_nxt.hue_dsh = data_in.hue_dsh >> 1;
    valid_nxt        = valid_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: src/rgbhsv_post.sv
module rgbhsv_post (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_in,
  input  rgbhsv_pkg::stage_t           data_in,
  output logic                         valid_r,
  output logic [rgbhsv_pkg::PIX_W-1:0] hue_r,
  output logic [rgbhsv_pkg::PIX_W-1:0] sat_r,
  output logic [rgbhsv_pkg::PIX_W-1:0] value_r
);

  logic                         valid_nxt;
  logic [rgbhsv_pkg::PIX_W-1:0] hue_nxt;
  logic [rgbhsv_pkg::PIX_W-1:0] sat_nxt;
  logic [rgbhsv_pkg::PIX_W-1:0] value_nxt;

  // A black pixel divided by a zero value, so its saturation is forced to zero.
  // A grey or black pixel has a zero saturation and gets hue zero;
  // its hue quotient is meaningless because chroma was zero.
  always_comb begin
    valid_nxt = valid_in;
    sat_nxt   = (data_in.value == '0) ? '0 : data_in.sat_q;
    value_nxt = data_in.value;
    if (sat_nxt == '0) begin
      hue_nxt = '0;
    end else if (data_in.hue_neg) begin
      hue_nxt = data_in.hue_base - data_in.hue_q;
    end else begin
      hue_nxt = data_in.hue_base + data_in.hue_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hue_r   <= hue_nxt;
    sat_r   <= sat_nxt;
    value_r <= value_nxt;
  end

endmodule

FILE: src/rgb_to_hsv_8bit.sv
// RGB to HSV conversion of 8-bit pixels.
// Input: drive in_red_level, in_green_level and in_blue_level and raise start;
// the item is taken at the clock edge where start is high and busy is low.
// busy is always low, so a new item may be given in every cycle.
// Output: out_valid is high for exactly one cycle with out_hue_out,
// out_saturation_out and out_value_out; the receiver must take it then.
// From the accepting edge an item passes one preparation register, a chain
// of eight divider cells (one quotient bit each for saturation and hue), and
// one output register.
// Throughput is one item per cycle; the chain holds up to ten items in flight.
// Results leave in the order items were taken.
// Synchronous reset (rst_n low) clears every valid bit, dropping items in
// flight; pixel data in the chain is not cleared.
module rgb_to_hsv_8bit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_red_level,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_green_level,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_blue_level,
  output logic                         out_valid,
  output logic [rgbhsv_pkg::PIX_W-1:0] out_hue_out,
  output logic [rgbhsv_pkg::PIX_W-1:0] out_saturation_out,
  output logic [rgbhsv_pkg::PIX_W-1:0] out_value_out
);

  logic                      accept;
  logic                      chain_valid [rgbhsv_pkg::NUM_CELLS+1];
  rgbhsv_pkg::stage_t        chain_data  [rgbhsv_pkg::NUM_CELLS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rgbhsv_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .red_level   (in_red_level),
    .green_level (in_green_level),
    .blue_level  (in_blue_level),
    .valid_r     (chain_valid[0]),
    .data_r      (chain_data[0])
  );

  for (genvar i = 0; i < rgbhsv_pkg::NUM_CELLS; i++) begin : g_cell
    rgbhsv_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (chain_valid[i]),
      .data_in  (chain_data[i]),
      .valid_r  (chain_valid[i+1]),
      .data_r   (chain_data[i+1])
    );
  end

  rgbhsv_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (chain_valid[rgbhsv_pkg::NUM_CELLS]),
    .data_in  (chain_data[rgbhsv_pkg::NUM_CELLS]),
    .valid_r  (out_valid),
    .hue_r    (out_hue_out),
    .sat_r    (out_saturation_out),
    .value_r  (out_value_out)
  );

  // Every accepted item must come out of the chain as a valid result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##10 out_valid)
    else $error("item did not leave the chain after ten cycles");

  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 10))
    else $error("result without a matching accepted item");

  // A black pixel has no chroma, so saturation must come out zero.
  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value_out == '0) |-> out_saturation_out == '0)
    else $error("nonzero saturation for a black pixel");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation_out != '0) |-> out_value_out != '0)
    else $error("saturation set with zero value");

endmodule
